/* design/mrfd_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte step for the meter response frame decoder.
// It has no dependencies. The front, queue, back and top level modules import it.
package mrfd_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [POS_W-1:0] POS_VOLTAGE = POS_W'(3);
	localparam logic [POS_W-1:0] POS_CURRENT = POS_W'(5);
	localparam logic [POS_W-1:0] POS_POWER   = POS_W'(9);
	localparam logic [POS_W-1:0] POS_ENERGY  = POS_W'(13);
	localparam logic [POS_W-1:0] POS_FREQ    = POS_W'(17);
	localparam logic [POS_W-1:0] POS_PF      = POS_W'(19);
	localparam logic [POS_W-1:0] POS_ALARM   = POS_W'(21);
	localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

	typedef struct packed {
		logic             timeout;
		logic             last;
		logic             crc_en;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
	} cmd_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* design/mrfd_front.sv */
// Front end of the meter response frame decoder: accepts words, tracks byte position, classifies.
// Depends on mrfd_pkg; feeds mrfd_queue.
module mrfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          action,
	input  logic [7:0]    rx_byte,
	input  logic          q_full,
	output logic          push,
	output mrfd_pkg::cmd_t cmd
);
	import mrfd_pkg::*;

	logic [POS_W-1:0] byte_count_q;

	always_comb begin
		in_stall    = q_full;
		push        = in_valid && !q_full;
		cmd.timeout = (action == ACT_TIMEOUT);
		cmd.last    = (action == ACT_BYTE) && (byte_count_q == POS_LAST);
		cmd.crc_en  = (action == ACT_BYTE) && (byte_count_q < POS_CRC_LO);
		cmd.pos     = byte_count_q;
		cmd.data    = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
		end else if (push) begin
			if (cmd.timeout || cmd.last) begin
				byte_count_q <= '0;
			end else begin
				byte_count_q <= byte_count_q + POS_W'(1);
			end
		end
	end

endmodule

/* design/mrfd_queue.sv */
// Short queue of classified commands between the front and back ends.
// Depends on mrfd_pkg.
module mrfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrfd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output mrfd_pkg::cmd_t head
);
	import mrfd_pkg::*;

	cmd_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/mrfd_back.sv */
// Back end of the meter response frame decoder: runs the CRC, assembles fields, holds the result.
// Depends on mrfd_pkg; takes commands from mrfd_queue.
module mrfd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  mrfd_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          frame_ok,
	output logic [15:0]   voltage_raw,
	output logic [31:0]   current_raw,
	output logic [31:0]   power_raw,
	output logic [31:0]   energy_raw,
	output logic [15:0]   frequency_raw,
	output logic [15:0]   power_factor_raw,
	output logic [15:0]   alarm_word
);
	import mrfd_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic [15:0] voltage_q;
	logic [31:0] current_q;
	logic [31:0] power_q;
	logic [31:0] energy_q;
	logic [15:0] freq_q;
	logic [15:0] pf_q;
	logic [15:0] alarm_q;
	logic        out_valid_q;
	logic        ends_frame;
	logic        emit;
	logic        ok;

	always_comb begin
		ends_frame = head.timeout || head.last;
		pop        = !q_empty && (!ends_frame || !out_valid_q || !out_stall);
		emit       = pop && ends_frame;
		ok         = head.last && ({head.data, crc_lo_q} == crc_q);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (ends_frame) begin
					crc_q <= CRC_INIT;
				end else if (head.crc_en) begin
					crc_q <= crc16_byte(crc_q, head.data);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head.timeout) begin
			case (head.pos)
				POS_VOLTAGE:            voltage_q[15:8]  <= head.data;
				POS_VOLTAGE + POS_W'(1): voltage_q[7:0]  <= head.data;
				POS_CURRENT:            current_q[15:8]  <= head.data;
				POS_CURRENT + POS_W'(1): current_q[7:0]  <= head.data;
				POS_CURRENT + POS_W'(2): current_q[31:24] <= head.data;
				POS_CURRENT + POS_W'(3): current_q[23:16] <= head.data;
				POS_POWER:              power_q[15:8]    <= head.data;
				POS_POWER + POS_W'(1):  power_q[7:0]     <= head.data;
				POS_POWER + POS_W'(2):  power_q[31:24]   <= head.data;
				POS_POWER + POS_W'(3):  power_q[23:16]   <= head.data;
				POS_ENERGY:             energy_q[15:8]   <= head.data;
				POS_ENERGY + POS_W'(1): energy_q[7:0]    <= head.data;
				POS_ENERGY + POS_W'(2): energy_q[31:24]  <= head.data;
				POS_ENERGY + POS_W'(3): energy_q[23:16]  <= head.data;
				POS_FREQ:               freq_q[15:8]     <= head.data;
				POS_FREQ + POS_W'(1):   freq_q[7:0]      <= head.data;
				POS_PF:                 pf_q[15:8]       <= head.data;
				POS_PF + POS_W'(1):     pf_q[7:0]        <= head.data;
				POS_ALARM:              alarm_q[15:8]    <= head.data;
				POS_ALARM + POS_W'(1):  alarm_q[7:0]     <= head.data;
				POS_CRC_LO:             crc_lo_q         <= head.data;
				default:                ;
			endcase
		end
		if (emit) begin
			frame_ok         <= ok;
			voltage_raw      <= ok ? voltage_q : '0;
			current_raw      <= ok ? current_q : '0;
			power_raw        <= ok ? power_q : '0;
			energy_raw       <= ok ? energy_q : '0;
			frequency_raw    <= ok ? freq_q : '0;
			power_factor_raw <= ok ? pf_q : '0;
			alarm_word       <= ok ? alarm_q : '0;
		end
	end

endmodule

/* design/meter_response_frame_decoder.sv */
// Top level of the meter response frame decoder: front end, command queue and back end.
// Depends on mrfd_pkg, mrfd_front, mrfd_queue and mrfd_back.
// One word per cycle is taken while in_stall is low; the back end retires one command per cycle
// unless a frame end waits on a stalled output word. The edge popping the final byte or timeout
// word sets out_valid; the pop waits on earlier queued words or a stalled output word. Reset
// clears byte position, queue, CRC and output valid at once; field registers have no reset.
module meter_response_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [15:0] voltage_raw,
	output logic [31:0] current_raw,
	output logic [31:0] power_raw,
	output logic [31:0] energy_raw,
	output logic [15:0] frequency_raw,
	output logic [15:0] power_factor_raw,
	output logic [15:0] alarm_word
);
	import mrfd_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	mrfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	mrfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	mrfd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_ok         (frame_ok),
		.voltage_raw      (voltage_raw),
		.current_raw      (current_raw),
		.power_raw        (power_raw),
		.energy_raw       (energy_raw),
		.frequency_raw    (frequency_raw),
		.power_factor_raw (power_factor_raw),
		.alarm_word       (alarm_word)
	);

endmodule

/* design/mrfd_checker.sv */
// Port-level checks for the meter response frame decoder, bound to the top level.
// It has no dependencies beyond the top level's ports.
module mrfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        frame_ok,
	input logic [15:0] voltage_raw,
	input logic [31:0] current_raw,
	input logic [31:0] power_raw,
	input logic [31:0] energy_raw,
	input logic [15:0] frequency_raw,
	input logic [15:0] power_factor_raw,
	input logic [15:0] alarm_word
);

	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_ok) && $stable(current_raw))
		else $error("stalled output word changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> voltage_raw == 16'h0 && current_raw == 32'h0
			&& power_raw == 32'h0 && energy_raw == 32'h0 && frequency_raw == 16'h0
			&& power_factor_raw == 16'h0 && alarm_word == 16'h0)
		else $error("failed frame carries nonzero values");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output word waiting");

endmodule

bind meter_response_frame_decoder mrfd_checker u_mrfd_checker (.*);
